[hw/rtl/pwvs_pkg.sv]
// Package for the plane-wave velocity sum unit: widths, fixed-point constants,
// sequencer states and the CORDIC angle table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pwvs_pkg;
	localparam int unsigned AMP_W = 32;
	localparam int unsigned VEC_W = 32;
	localparam int unsigned K_W   = 48;
	localparam int unsigned VEL_W = 48;
	localparam int unsigned CFG_W = 6;
	localparam int unsigned IDX_W = 5;

	localparam logic [21:0] TURN_PER_RAD_Q24 = 22'd2670177;
	localparam logic [31:0] CORDIC_GAIN_Q30  = 32'd652032874;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DOT,
		ST_TURN,
		ST_PHASE,
		ST_CORDIC,
		ST_ROT,
		ST_MIX,
		ST_POL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] amp_re;
		logic signed [AMP_W-1:0] amp_im;
		logic [K_W-1:0]          wavenumber;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] dir_z;
		logic signed [VEC_W-1:0] pol_x;
		logic signed [VEC_W-1:0] pol_y;
		logic signed [VEC_W-1:0] pol_z;
	} shell_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] s);
		logic [31:0] r;
		case (s)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/pwvs_if.sv]
// Valid/ready channel interfaces for the plane-wave velocity sum unit.
// Depends on pwvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pwvs_req_if import pwvs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic [IDX_W-1:0]        shell_index;
	logic signed [AMP_W-1:0] amp_re;
	logic signed [AMP_W-1:0] amp_im;
	logic [K_W-1:0]          wavenumber;
	logic signed [VEC_W-1:0] vec_a_x;
	logic signed [VEC_W-1:0] vec_a_y;
	logic signed [VEC_W-1:0] vec_a_z;
	logic signed [VEC_W-1:0] pol_x;
	logic signed [VEC_W-1:0] pol_y;
	logic signed [VEC_W-1:0] pol_z;
	modport source (output valid, mode, shell_index, amp_re, amp_im, wavenumber,
		vec_a_x, vec_a_y, vec_a_z, pol_x, pol_y, pol_z, input ready);
	modport sink (input valid, mode, shell_index, amp_re, amp_im, wavenumber,
		vec_a_x, vec_a_y, vec_a_z, pol_x, pol_y, pol_z, output ready);
endinterface

interface pwvs_rsp_if import pwvs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic signed [VEL_W-1:0] vel_z;
	logic                    saturated;
	modport source (output valid, vel_x, vel_y, vel_z, saturated, input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, saturated, output ready);
endinterface

interface pwvs_cfg_if import pwvs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/plane_wave_velocity_sum_unit.sv]
// Top level of the plane-wave velocity sum unit: shell table, sequencer,
// shared multiplier and CORDIC. Depends on pwvs_pkg, pwvs_if and pwvs_mul.
//
// Usage: req carries load requests (mode 0, one shell entry written, no
// response) and evaluate requests (mode 1, a point; one response with the
// velocity vector). cfg writes active_shells (clamped to MAX_SHELLS, zero
// sums nothing); write it only while the unit is idle.
// Timing: a load is written to the table on the edge that accepts it. An
// evaluate runs the active shells one after another, all of it set by one shared
// multiplier and one CORDIC stage reused each step; the sequencer returns to
// idle on the same edge that raises the response, so the next request can follow.
// req.ready is low while an evaluate is in progress; a stalled receiver holds
// the response in its output register, and a finished sum waits until it is
// free.
// Reset: active_shells returns to 32 and the sequencer to idle; the shell
// table is not cleared, so shells must be loaded before they are evaluated.
`timescale 1ns / 1ps
`default_nettype none
module plane_wave_velocity_sum_unit import pwvs_pkg::*; #(
	parameter int unsigned MAX_SHELLS   = 32,
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  wire        clk,
	input  wire        arst_n,
	pwvs_req_if.sink   req,
	pwvs_cfg_if.sink   cfg,
	pwvs_rsp_if.source rsp
);
	localparam int unsigned SH_W = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_SHELLS + 1);
	localparam int unsigned ST_W = $clog2(CORDIC_STEPS + 1);

	seq_state_t state_q, state_nx;
	logic [CFG_W-1:0] active_q;
	shell_t mem [MAX_SHELLS];
	shell_t sh_q;
	logic [CNT_W-1:0] shell_q, count_q, count_nx;
	logic [3:0] sub_q;
	logic [ST_W-1:0] step_q;
	logic signed [VEC_W-1:0] pt_q [3];
	logic signed [63:0] dot_q;
	logic signed [63:0] acc_q [3];
	logic signed [63:0] tmp_q;
	logic [47:0] kacc_q, ksum;
	logic [31:0] phase_q;
	logic [1:0] quad_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [33:0] co_q, si_q;
	logic signed [63:0] re_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic signed [33:0] ysh, xsh;
	logic [4:0] s5;
	logic sub_last, shells_left, done_go;
	logic signed [VEL_W-1:0] sat_v [3];
	logic sat_f [3];

	logic req_fire, cfg_fire;
	assign req_fire = req.valid && req.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// hold the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(32);
		end else if (cfg_fire) begin
			active_q <= cfg.data;
		end
	end

	// clamp the register to the table size
	assign count_nx = (32'(active_q) > MAX_SHELLS) ? CNT_W'(MAX_SHELLS) : CNT_W'(active_q);

	// shell table write and read
	always_ff @(posedge clk) begin
		if (req_fire && req.mode == MODE_LOAD && 32'(req.shell_index) < MAX_SHELLS) begin
			mem[SH_W'(req.shell_index)] <= '{req.amp_re, req.amp_im, req.wavenumber,
				req.vec_a_x, req.vec_a_y, req.vec_a_z, req.pol_x, req.pol_y, req.pol_z};
		end
		sh_q <= mem[SH_W'(shell_q)];
	end

	pwvs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_DOT: begin
				case (sub_q)
					4'd0: begin ma = 33'(sh_q.dir_x); mb = 33'(pt_q[0]); end
					4'd1: begin ma = 33'(sh_q.dir_y); mb = 33'(pt_q[1]); end
					4'd2: begin ma = 33'(sh_q.dir_z); mb = 33'(pt_q[2]); end
					default: ;
				endcase
			end
			ST_TURN: begin
				// upper and lower parts of the projection in turn
				case (sub_q)
					4'd0: ma = 33'(dot_q >>> 46);
					4'd1: ma = 33'(dot_q[45:22]);
					default: ;
				endcase
				mb = 33'(signed'({1'b0, TURN_PER_RAD_Q24}));
			end
			ST_PHASE: begin
				// 24-bit partial products of wavenumber times turns
				case (sub_q)
					4'd0: begin
						ma = 33'(sh_q.wavenumber[23:0]);
						mb = 33'(tmp_q[23:0]);
					end
					4'd1: begin
						ma = 33'(sh_q.wavenumber[47:24]);
						mb = 33'(tmp_q[23:0]);
					end
					4'd2: begin
						ma = 33'(sh_q.wavenumber[23:0]);
						mb = 33'(tmp_q[47:24]);
					end
					default: ;
				endcase
			end
			ST_MIX: begin
				case (sub_q)
					4'd0: begin ma = 33'(sh_q.amp_re); mb = 33'(co_q); end
					4'd1: begin ma = 33'(sh_q.amp_im); mb = 33'(si_q); end
					default: ;
				endcase
			end
			ST_POL: begin
				case (sub_q)
					4'd0: begin ma = 33'(sh_q.pol_x); mb = 33'(signed'(re_q)); end
					4'd1: begin ma = 33'(sh_q.pol_y); mb = 33'(signed'(re_q)); end
					4'd2: begin ma = 33'(sh_q.pol_z); mb = 33'(signed'(re_q)); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// fold in the cross terms, only the low 48 bits of the product matter
	assign ksum = kacc_q + {mp[23:0], 24'd0};
	assign s5 = 5'(step_q);
	assign ysh = cy_q >>> s5;
	assign xsh = cx_q >>> s5;
	assign sub_last = (sub_q == 4'd3);
	assign shells_left = (shell_q + CNT_W'(1)) < count_q;
	assign done_go = (state_q == ST_DONE) && (!rsp.valid || rsp.ready);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (req_fire && req.mode == MODE_EVAL)
				state_nx = (count_nx == '0) ? ST_DONE : ST_READ;
			ST_READ: state_nx = ST_DOT;
			ST_DOT: if (sub_last) state_nx = ST_TURN;
			ST_TURN: if (sub_q == 4'd2) state_nx = ST_PHASE;
			ST_PHASE: if (sub_q == 4'd4) state_nx = ST_CORDIC;
			ST_CORDIC: if (32'(step_q) == CORDIC_STEPS - 1) state_nx = ST_ROT;
			ST_ROT: state_nx = ST_MIX;
			ST_MIX: if (sub_q == 4'd2) state_nx = ST_POL;
			ST_POL: if (sub_last) state_nx = shells_left ? ST_READ : ST_DONE;
			ST_DONE: if (done_go) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sat_f[a] = (acc_q[a] > 64'sd140737488355327) ||
				(acc_q[a] < -64'sd140737488355328);
			sat_v[a] = (acc_q[a] > 64'sd140737488355327) ? {1'b0, {(VEL_W-1){1'b1}}} :
				(acc_q[a] < -64'sd140737488355328) ? {1'b1, {(VEL_W-1){1'b0}}} :
				acc_q[a][VEL_W-1:0];
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q <= '0;
			step_q <= '0;
			shell_q <= '0;
			count_q <= '0;
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (done_go) rsp.valid <= 1'b1;
			else if (rsp.ready) rsp.valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					sub_q <= '0;
					shell_q <= '0;
					count_q <= count_nx;
					pt_q[0] <= req.vec_a_x;
					pt_q[1] <= req.vec_a_y;
					pt_q[2] <= req.vec_a_z;
					for (int a = 0; a < 3; a++) acc_q[a] <= '0;
				end
				ST_READ: begin
					sub_q <= '0;
					dot_q <= '0;
				end
				ST_DOT: begin
					// registered product of the previous axis is added in the next step
					if (sub_q != 4'd0) dot_q <= dot_q + 64'(mp >>> 2);
					sub_q <= sub_last ? 4'd0 : sub_q + 4'd1;
				end
				ST_TURN: begin
					if (sub_q == 4'd1) tmp_q <= 64'(mp);
					if (sub_q == 4'd2) tmp_q <= tmp_q + 64'(mp >>> 24);
					sub_q <= (sub_q == 4'd2) ? 4'd0 : sub_q + 4'd1;
				end
				ST_PHASE: begin
					case (sub_q)
						4'd1: kacc_q <= mp[47:0];
						4'd2: kacc_q <= ksum;
						4'd3: phase_q <= ksum[45:14];
						4'd4: begin
							quad_q <= 2'((phase_q + 32'h2000_0000) >> 30);
							cz_q <= 34'(signed'(phase_q -
								{2'((phase_q + 32'h2000_0000) >> 30), 30'd0}));
							cx_q <= 34'(CORDIC_GAIN_Q30);
							cy_q <= '0;
							step_q <= '0;
						end
						default: ;
					endcase
					sub_q <= (sub_q == 4'd4) ? 4'd0 : sub_q + 4'd1;
				end
				ST_CORDIC: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ysh;
						cy_q <= cy_q + xsh;
						cz_q <= cz_q - 34'(atan_turns(s5));
					end else begin
						cx_q <= cx_q + ysh;
						cy_q <= cy_q - xsh;
						cz_q <= cz_q + 34'(atan_turns(s5));
					end
					step_q <= step_q + ST_W'(1);
				end
				ST_ROT: begin
					case (quad_q)
						2'd0: begin co_q <= cx_q; si_q <= cy_q; end
						2'd1: begin co_q <= -cy_q; si_q <= cx_q; end
						2'd2: begin co_q <= -cx_q; si_q <= -cy_q; end
						default: begin co_q <= cy_q; si_q <= -cx_q; end
					endcase
					sub_q <= '0;
				end
				ST_MIX: begin
					if (sub_q == 4'd1) tmp_q <= 64'(mp);
					if (sub_q == 4'd2) re_q <= (tmp_q - 64'(mp)) >>> 30;
					sub_q <= (sub_q == 4'd2) ? 4'd0 : sub_q + 4'd1;
				end
				ST_POL: begin
					if (sub_q != 4'd0)
						acc_q[2'(sub_q - 4'd1)] <= acc_q[2'(sub_q - 4'd1)] + 64'(mp >>> 29);
					sub_q <= sub_last ? 4'd0 : sub_q + 4'd1;
					if (sub_last) shell_q <= shell_q + CNT_W'(1);
				end
				ST_DONE: begin
					// hold the sum until the output register is free
					if (done_go) begin
						rsp.vel_x <= sat_v[0];
						rsp.vel_y <= sat_v[1];
						rsp.vel_z <= sat_v[2];
						rsp.saturated <= sat_f[0] | sat_f[1] | sat_f[2];
					end
				end
				default: ;
			endcase
		end
	end

	// read address follows the shell counter
	// (table read is registered in sh_q during ST_READ)

	// no new request while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("ready while busy");
	// response appears only after a finished sum
	a_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == ST_DONE) else $error("stray response");
	// shell counter never passes the count
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> shell_q < count_q) else $error("shell overrun");
endmodule
`default_nettype wire

[hw/rtl/pwvs_mul.sv]
// Shared signed 33x33 multiplier with registered product for the sequencer.
// Depends on pwvs_pkg only through the house import.
`timescale 1ns / 1ps
`default_nettype none
module pwvs_mul import pwvs_pkg::*; (
	input  wire                clk,
	input  wire signed [32:0]  a,
	input  wire signed [32:0]  b,
	output logic signed [65:0] p_q
);
	// register every product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

[verif/plane_wave_velocity_sum_unit_test.sv]
// Self-checking testbench for the plane-wave velocity sum unit: a directed table
// followed by random load/evaluate requests, checked against a local predictor.
// Depends on pwvs_pkg, pwvs_if and plane_wave_velocity_sum_unit.
`timescale 1ns / 1ps
module plane_wave_velocity_sum_unit_test;
	import pwvs_pkg::*;

	localparam int NUM_SHELLS   = 32;
	localparam int ROT_STEPS    = 24;
	localparam int STALL_LIMIT  = 20000;
	localparam int LONG_HOLD    = 3000;
	localparam int SETTLE_WAIT  = 8;
	localparam longint VEL_MAX  = 64'sd140737488355327;
	localparam longint VEL_MIN  = -64'sd140737488355328;

	// Arctangent of 2^-i in Q0.32 turns, one entry per rotation step
	localparam longint ROT_ANGLE [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
		652, 326, 163, 81};

	typedef struct packed {
		logic signed [VEL_W-1:0] x;
		logic signed [VEL_W-1:0] y;
		logic signed [VEL_W-1:0] z;
		logic                    sat;
	} velocity_t;

	typedef struct {
		bit                      is_cfg;
		logic [CFG_W-1:0]        cfg_val;
		logic                    mode;
		logic [IDX_W-1:0]        idx;
		logic signed [AMP_W-1:0] are;
		logic signed [AMP_W-1:0] aim;
		logic [K_W-1:0]          k;
		logic signed [VEC_W-1:0] ax, ay, az;
		logic signed [VEC_W-1:0] px, py, pz;
		bit                      typed;
		velocity_t               fixed_vel;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pwvs_req_if req ();
	pwvs_cfg_if cfg ();
	pwvs_rsp_if rsp ();

	plane_wave_velocity_sum_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.rsp    (rsp)
	);

	always #4 clk = ~clk;

	// Predictor copy of the shell table and register
	logic signed [AMP_W-1:0] tab_are [NUM_SHELLS];
	logic signed [AMP_W-1:0] tab_aim [NUM_SHELLS];
	logic [K_W-1:0]          tab_k   [NUM_SHELLS];
	logic signed [VEC_W-1:0] tab_dir [NUM_SHELLS][3];
	logic signed [VEC_W-1:0] tab_pol [NUM_SHELLS][3];
	logic [CFG_W-1:0]        active_reg = 6'd32;

	velocity_t pending_velocity [$];
	stim_row_t directed_rows [$];
	int unsigned mismatches = 0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned hold_asked = 0;

	function automatic velocity_t predict_velocity(input logic signed [VEC_W-1:0] px,
			input logic signed [VEC_W-1:0] py, input logic signed [VEC_W-1:0] pz);
		longint acc [3];
		longint dot, d, dt, x, y, z, nx, co, si, re;
		logic [63:0] prod;
		logic [31:0] ph, shifted, resid;
		logic [1:0] quad;
		int cnt;
		velocity_t v;
		acc = '{0, 0, 0};
		v.sat = 1'b0;
		cnt = (active_reg > NUM_SHELLS) ? NUM_SHELLS : int'(active_reg);
		for (int n = 0; n < cnt; n++) begin
			// Project the point on the direction and turn radians into turns
			dot = ((longint'(tab_dir[n][0]) * longint'(px)) >>> 2)
				+ ((longint'(tab_dir[n][1]) * longint'(py)) >>> 2)
				+ ((longint'(tab_dir[n][2]) * longint'(pz)) >>> 2);
			d = dot >>> 22;
			dt = (d * longint'(TURN_PER_RAD_Q24)) >>> 24;
			prod = {16'd0, tab_k[n]} * 64'(dt);
			ph = prod[45:14];
			// Split off the nearest quadrant, rotate the residual
			shifted = ph + 32'h2000_0000;
			quad = shifted[31:30];
			resid = ph - {quad, 30'd0};
			z = longint'(signed'(resid));
			x = longint'(CORDIC_GAIN_Q30);
			y = 0;
			for (int i = 0; i < ROT_STEPS; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - ROT_ANGLE[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + ROT_ANGLE[i];
				end
				x = nx;
			end
			case (quad)
				2'd0: begin co = x;  si = y;  end
				2'd1: begin co = -y; si = x;  end
				2'd2: begin co = -x; si = -y; end
				default: begin co = y; si = -x; end
			endcase
			re = (longint'(tab_are[n]) * co - longint'(tab_aim[n]) * si) >>> 30;
			for (int a = 0; a < 3; a++)
				acc[a] += (longint'(tab_pol[n][a]) * re) >>> 29;
		end
		// Clip each component to the output width
		for (int a = 0; a < 3; a++) begin
			if (acc[a] > VEL_MAX) begin
				acc[a] = VEL_MAX;
				v.sat = 1'b1;
			end
			if (acc[a] < VEL_MIN) begin
				acc[a] = VEL_MIN;
				v.sat = 1'b1;
			end
		end
		v.x = acc[0][VEL_W-1:0];
		v.y = acc[1][VEL_W-1:0];
		v.z = acc[2][VEL_W-1:0];
		return v;
	endfunction

	function automatic stim_row_t row_load(input logic [IDX_W-1:0] idx,
			input logic signed [AMP_W-1:0] are, input logic signed [AMP_W-1:0] aim,
			input logic [K_W-1:0] k, input logic signed [VEC_W-1:0] dx,
			input logic signed [VEC_W-1:0] dy, input logic signed [VEC_W-1:0] dz,
			input logic signed [VEC_W-1:0] px, input logic signed [VEC_W-1:0] py,
			input logic signed [VEC_W-1:0] pz);
		stim_row_t r;
		r = '{default: '0};
		r.mode = MODE_LOAD;
		r.idx = idx;
		r.are = are;
		r.aim = aim;
		r.k = k;
		r.ax = dx;
		r.ay = dy;
		r.az = dz;
		r.px = px;
		r.py = py;
		r.pz = pz;
		return r;
	endfunction

	function automatic stim_row_t row_eval(input logic signed [VEC_W-1:0] x,
			input logic signed [VEC_W-1:0] y, input logic signed [VEC_W-1:0] z,
			input bit typed);
		stim_row_t r;
		r = '{default: '0};
		r.mode = MODE_EVAL;
		r.ax = x;
		r.ay = y;
		r.az = z;
		r.typed = typed;
		return r;
	endfunction

	function automatic stim_row_t row_cfg(input logic [CFG_W-1:0] v);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic stim_row_t random_row(input int unsigned load_pct);
		stim_row_t r;
		r = '{default: '0};
		r.mode = ($urandom_range(99) < load_pct) ? MODE_LOAD : MODE_EVAL;
		r.idx = IDX_W'($urandom);
		r.are = $urandom;
		r.aim = $urandom;
		r.k = {16'($urandom), 32'($urandom)};
		r.ax = $urandom;
		r.ay = $urandom;
		r.az = $urandom;
		r.px = $urandom;
		r.py = $urandom;
		r.pz = $urandom;
		return r;
	endfunction

	// Update the table on a load, queue the expected velocity on an evaluate
	function automatic void note_request(input stim_row_t r);
		if (r.mode == MODE_LOAD) begin
			tab_are[r.idx] = r.are;
			tab_aim[r.idx] = r.aim;
			tab_k[r.idx] = r.k;
			tab_dir[r.idx] = '{r.ax, r.ay, r.az};
			tab_pol[r.idx] = '{r.px, r.py, r.pz};
		end else if (r.typed)
			pending_velocity.push_back(r.fixed_vel);
		else
			pending_velocity.push_back(predict_velocity(r.ax, r.ay, r.az));
	endfunction

	task automatic send_request(input stim_row_t r);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= r.mode;
		req.shell_index <= r.idx;
		req.amp_re <= r.are;
		req.amp_im <= r.aim;
		req.wavenumber <= r.k;
		req.vec_a_x <= r.ax;
		req.vec_a_y <= r.ay;
		req.vec_a_z <= r.az;
		req.pol_x <= r.px;
		req.pol_y <= r.py;
		req.pol_z <= r.pz;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		note_request(r);
	endtask

	task automatic drain_requests();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_velocity.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_active(input logic [CFG_W-1:0] v);
		drain_requests();
		repeat (SETTLE_WAIT) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		active_reg = v;
	endtask

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Compare each response with the oldest expected velocity
	always @(posedge clk) begin
		velocity_t got, want;
		if (rsp.valid && rsp.ready) begin
			got = '{rsp.vel_x, rsp.vel_y, rsp.vel_z, rsp.saturated};
			if (pending_velocity.size() == 0) begin
				$display("%0t unexpected response %h", $time, got);
				mismatches++;
			end else begin
				want = pending_velocity.pop_front();
				if (got !== want) begin
					$display("%0t velocity mismatch: expected x %h y %h z %h sat %b, actual x %h y %h z %h sat %b",
						$time, want.x, want.y, want.z, want.sat,
						got.x, got.y, got.z, got.sat);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run after a long stretch with no transfer on any channel
	always @(posedge clk) begin
		int unsigned quiet;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_cfg [24];
		int unsigned per_phase;
		stim_row_t r;
		phase_cfg = '{6'd32, 6'd1, 6'd63, 6'd2, 6'd3, 6'd33, 6'd1, 6'd4, 6'd0, 6'd2, 6'd5,
			6'd32, 6'd3, 6'd1, 6'd6, 6'd2, 6'd4, 6'd1, 6'd3, 6'd2, 6'd7, 6'd1, 6'd2, 6'd3};

		req.valid = 1'b0;
		req.mode = MODE_LOAD;
		req.shell_index = '0;
		req.amp_re = '0;
		req.amp_im = '0;
		req.wavenumber = '0;
		req.vec_a_x = '0;
		req.vec_a_y = '0;
		req.vec_a_z = '0;
		req.pol_x = '0;
		req.pol_y = '0;
		req.pol_z = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;

		// Directed rows: zero register, extremes, zero amplitude, small tables
		directed_rows.push_back(row_cfg(6'd0));
		directed_rows.push_back(row_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
		directed_rows.push_back(row_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
		directed_rows.push_back(row_cfg(6'd1));
		directed_rows.push_back(row_load(5'd0, 32'h7fff_ffff, 32'h8000_0000, 48'hffff_ffff_ffff,
			32'h4000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000));
		directed_rows.push_back(row_eval(32'h0, 32'h0, 32'h0, 1'b0));
		directed_rows.push_back(row_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
		directed_rows.push_back(row_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
		directed_rows.push_back(row_load(5'd0, 32'h0, 32'h0, 48'h1_0000, 32'h4000_0000,
			32'h0, 32'h0, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
		directed_rows.push_back(row_eval(32'h0100_0000, 32'h0, 32'h0, 1'b1));
		directed_rows.push_back(row_load(5'd0, 32'h8000_0000, 32'h7fff_ffff, 48'h0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		directed_rows.push_back(row_eval(32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b0));
		directed_rows.push_back(row_cfg(6'd2));
		directed_rows.push_back(row_load(5'd1, 32'h7fff_ffff, 32'h7fff_ffff, 48'h1_0000,
			32'h0, 32'h4000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
		directed_rows.push_back(row_eval(32'h0100_0000, 32'h0, 32'hff00_0000, 1'b0));
		directed_rows.push_back(row_eval(32'h0, 32'h0100_0000, 32'h0, 1'b0));
		directed_rows.push_back(row_cfg(6'd3));
		directed_rows.push_back(row_load(5'd2, 32'h0001_0000, 32'h0, 48'h6_4000, 32'h2d41_3ccd,
			32'h2d41_3ccd, 32'h0, 32'h0, 32'h0, 32'h4000_0000));
		directed_rows.push_back(row_eval(32'h0080_0000, 32'h0080_0000, 32'h0, 1'b0));
		directed_rows.push_back(row_load(5'd31, 32'h1234_5678, 32'hedcb_a988, 48'h8000_0000_0000,
			32'h0, 32'h0, 32'hc000_0000, 32'h1, 32'hffff_ffff, 32'h2000_0000));
		directed_rows.push_back(row_eval(32'hff80_0000, 32'h0040_0000, 32'h7fff_ffff, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_active(directed_rows[i].cfg_val);
			else
				send_request(directed_rows[i]);
		end

		// Fill every shell so that any register setting reads written entries
		for (int n = 0; n < NUM_SHELLS; n++) begin
			r = random_row(100);
			r.idx = IDX_W'(n);
			send_request(r);
		end

		for (int p = 0; p < 24; p++) begin
			write_active(phase_cfg[p]);
			if (p < 8) begin
				send_idle = 6;
				recv_idle = 55;
			end else if (p < 16) begin
				send_idle = 55;
				recv_idle = 6;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			per_phase = (phase_cfg[p] >= 8) ? 24 : 86;
			for (int i = 0; i < per_phase; i++) begin
				// Hold the receiver off while requests keep coming
				if (p == 1 && i == 10)
					hold_asked++;
				// Pause the sender until every response is back
				if (p == 5 && i == 40)
					drain_requests();
				send_request(random_row(60));
			end
		end

		drain_requests();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
